// ----- sv/pat_pkg.sv -----
`timescale 1ns / 1ps
package pat_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int ST_W     = 3;
  localparam int FIDX_W   = 7;
  localparam int COUNT_W  = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_MAXIMUM = 3'd3,
    OP_MINIMUM = 3'd4,
    OP_REVERSE = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // SH_DOWN: take right neighbor; SH_UP: take left neighbor
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,
    SH_UP
  } shift_t;

  typedef struct packed {
    shift_t            mode;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic              wrap;
    logic [DATA_W-1:0] bus;
  } cell_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] result_value;
    logic [FIDX_W-1:0]        found_index;
    logic [COUNT_W-1:0]       entry_count;
  } rsp_t;

endpackage

// ----- sv/positional_array_table.sv -----
`timescale 1ns / 1ps
// channel  | handshake           | word
// ---------+---------------------+--------------------------------------
// request  | start / busy        | req : op, value, position
// result   | done (one cycle)    | rsp : status, result_value,
//          |                     |       found_index, entry_count
//
// Insert, delete, unused ops, and scans or reverse that need no pass: the accepted
// word is registered, then EXEC raises done. Search, max, min otherwise rotate
// the chain once past cell 0, which alone feeds the compare logic. Reverse with
// two or more entries runs REV, one prefix rotation per cycle.
// Busy stays high from accept until done; a new word may be taken while done is up.
// Reset clears the count and the sequencer; entries are not cleared.
// The receiver cannot stall: done is high for one cycle only.
module positional_array_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pat_pkg::req_t   req,
  output logic            done,
  output pat_pkg::rsp_t   rsp
);

  logic [pat_pkg::DATA_W-1:0] cell_data [pat_pkg::CAPACITY];
  pat_pkg::cell_cmd_t         cmd;

  pat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .head  (cell_data[0]),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  for (genvar i = 0; i < pat_pkg::CAPACITY; i++) begin : g_cell
    logic [pat_pkg::DATA_W-1:0] left;
    logic [pat_pkg::DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == pat_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    pat_cell u_cell (
      .clk   (clk),
      .idx   (pat_pkg::IDX_W'(i)),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .data  (cell_data[i])
    );
  end

endmodule

// ----- sv/pat_cell.sv -----
`timescale 1ns / 1ps
module pat_cell (
  input  logic                           clk,
  input  logic [pat_pkg::IDX_W-1:0]      idx,
  input  pat_pkg::cell_cmd_t             cmd,
  input  logic [pat_pkg::DATA_W-1:0]     left,
  input  logic [pat_pkg::DATA_W-1:0]     right,
  output logic [pat_pkg::DATA_W-1:0]     data
);

  logic                          we;
  logic [pat_pkg::DATA_W-1:0]    data_next;

  always_comb begin
    we        = 1'b0;
    data_next = right;
    case (cmd.mode)
      pat_pkg::SH_DOWN: begin
        if (idx >= cmd.lo && idx < cmd.hi) begin
          we        = 1'b1;
          data_next = right;
        end else if (idx == cmd.hi && cmd.wrap) begin
          we        = 1'b1;
          data_next = cmd.bus;
        end
      end
      pat_pkg::SH_UP: begin
        if (idx > cmd.lo && idx <= cmd.hi) begin
          we        = 1'b1;
          data_next = left;
        end else if (idx == cmd.lo) begin
          we        = 1'b1;
          data_next = cmd.bus;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      data <= data_next;
    end
  end

endmodule

// ----- sv/pat_ctrl.sv -----
`timescale 1ns / 1ps
module pat_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  pat_pkg::req_t               req,
  input  logic [pat_pkg::DATA_W-1:0]  head,
  output pat_pkg::cell_cmd_t          cmd,
  output logic                        done,
  output pat_pkg::rsp_t               rsp
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    SCAN,
    REV
  } state_t;

  state_t                          state;
  logic [pat_pkg::OP_W-1:0]        op_r;
  logic [pat_pkg::DATA_W-1:0]      val_r;
  logic [pat_pkg::POS_W-1:0]       pos_r;
  logic [pat_pkg::CNT_W-1:0]       count;
  logic [pat_pkg::CNT_W-1:0]       k;
  logic                            found;
  logic [pat_pkg::IDX_W-1:0]       fidx;
  logic [pat_pkg::DATA_W-1:0]      acc;

  logic [pat_pkg::CMP_W-1:0]       pos_ext;
  logic [pat_pkg::CMP_W-1:0]       cnt_ext;
  logic                            is_full;
  logic                            ins_ok;
  logic                            del_ok;
  logic [pat_pkg::CNT_W-1:0]       last;
  logic                            scan_last;
  logic                            hit;
  logic [pat_pkg::DATA_W-1:0]      acc_next;

  assign busy      = (state != IDLE);
  assign pos_ext   = pat_pkg::CMP_W'(pos_r);
  assign cnt_ext   = pat_pkg::CMP_W'(count);
  assign is_full   = (count >= pat_pkg::CNT_W'(pat_pkg::CAPACITY));
  assign ins_ok    = !is_full && (pos_ext <= cnt_ext);
  assign del_ok    = (count != '0) && (pos_ext < cnt_ext);
  assign last      = count - pat_pkg::CNT_W'(1);
  assign scan_last = (k == last);
  assign hit       = (head == val_r);

  always_comb begin
    if (k == '0) begin
      acc_next = head;
    end else if (op_r == pat_pkg::OP_MAXIMUM) begin
      acc_next = ($signed(head) > $signed(acc)) ? head : acc;
    end else begin
      acc_next = ($signed(head) < $signed(acc)) ? head : acc;
    end
  end

  always_comb begin
    cmd.mode = pat_pkg::SH_HOLD;
    cmd.lo   = '0;
    cmd.hi   = '0;
    cmd.wrap = 1'b0;
    cmd.bus  = head;
    unique case (state)
      EXEC: begin
        if (op_r == pat_pkg::OP_INSERT && ins_ok) begin
          cmd.mode = pat_pkg::SH_UP;
          cmd.lo   = pat_pkg::IDX_W'(pos_r);
          cmd.hi   = count[pat_pkg::IDX_W-1:0];
          cmd.bus  = val_r;
        end else if (op_r == pat_pkg::OP_DELETE && del_ok) begin
          cmd.mode = pat_pkg::SH_DOWN;
          cmd.lo   = pat_pkg::IDX_W'(pos_r);
          cmd.hi   = last[pat_pkg::IDX_W-1:0];
        end
      end
      SCAN: begin
        cmd.mode = pat_pkg::SH_DOWN;
        cmd.hi   = last[pat_pkg::IDX_W-1:0];
        cmd.wrap = 1'b1;
      end
      REV: begin
        // rotate the first k entries left by one
        cmd.mode = pat_pkg::SH_DOWN;
        cmd.hi   = pat_pkg::IDX_W'(k - pat_pkg::CNT_W'(1));
        cmd.wrap = 1'b1;
      end
      default: begin
        cmd.mode = pat_pkg::SH_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            op_r  <= req.op;
            val_r <= req.value;
            pos_r <= req.position;
            state <= EXEC;
          end
        end
        EXEC: begin
          rsp.status       <= pat_pkg::ST_OK;
          rsp.result_value <= '0;
          rsp.found_index  <= '0;
          rsp.entry_count  <= pat_pkg::COUNT_W'(count);
          k                <= '0;
          found            <= 1'b0;
          fidx             <= '0;
          state            <= IDLE;
          done             <= 1'b1;
          unique case (op_r) inside
            pat_pkg::OP_INSERT: begin
              if (is_full) begin
                rsp.status <= pat_pkg::ST_FULL;
              end else if (!ins_ok) begin
                rsp.status <= pat_pkg::ST_BADPOS;
              end else begin
                count           <= count + pat_pkg::CNT_W'(1);
                rsp.entry_count <= pat_pkg::COUNT_W'(count + pat_pkg::CNT_W'(1));
              end
            end
            pat_pkg::OP_DELETE: begin
              if (count == '0) begin
                rsp.status <= pat_pkg::ST_EMPTY;
              end else if (!del_ok) begin
                rsp.status <= pat_pkg::ST_BADPOS;
              end else begin
                count           <= last;
                rsp.entry_count <= pat_pkg::COUNT_W'(last);
              end
            end
            pat_pkg::OP_SEARCH: begin
              if (count == '0) begin
                rsp.status <= pat_pkg::ST_NOTFOUND;
              end else begin
                state <= SCAN;
                done  <= 1'b0;
              end
            end
            pat_pkg::OP_MAXIMUM, pat_pkg::OP_MINIMUM: begin
              if (count == '0) begin
                rsp.status       <= pat_pkg::ST_EMPTY;
                rsp.result_value <= '1;
              end else begin
                state <= SCAN;
                done  <= 1'b0;
              end
            end
            pat_pkg::OP_REVERSE: begin
              if (count > pat_pkg::CNT_W'(1)) begin
                k     <= count;
                state <= REV;
                done  <= 1'b0;
              end
            end
            default: begin
              rsp.status <= pat_pkg::ST_OK;
            end
          endcase
        end
        SCAN: begin
          k   <= k + pat_pkg::CNT_W'(1);
          acc <= acc_next;
          if (!found && hit) begin
            found <= 1'b1;
            fidx  <= k[pat_pkg::IDX_W-1:0];
          end
          if (scan_last) begin
            state <= IDLE;
            done  <= 1'b1;
            if (op_r == pat_pkg::OP_SEARCH) begin
              if (found) begin
                rsp.found_index <= pat_pkg::FIDX_W'(fidx);
              end else if (hit) begin
                rsp.found_index <= pat_pkg::FIDX_W'(k[pat_pkg::IDX_W-1:0]);
              end
              rsp.status <= (found || hit) ? pat_pkg::ST_OK : pat_pkg::ST_NOTFOUND;
            end else begin
              rsp.result_value <= acc_next;
            end
          end
        end
        REV: begin
          k <= k - pat_pkg::CNT_W'(1);
          if (k == pat_pkg::CNT_W'(2)) begin
            state <= IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == IDLE)
    else $error("result strobe while sequencer active");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= pat_pkg::CNT_W'(pat_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == EXEC)
    else $error("accepted word not executed");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == SCAN |-> k < count)
    else $error("scan step beyond stored entries");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.entry_count == pat_pkg::COUNT_W'(count))
    else $error("reported count differs from table count");
`endif

endmodule
